// File: rtl/core/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and codes of the generational slot pool: command and result
// items, command codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package gsp_pkg;

	// parameter defaults
	localparam int BLOCK_SLOTS_DEF = 8;
	localparam int MAX_BLOCKS_DEF  = 64;
	localparam int GEN_BITS_DEF    = 16;

	// command codes
	localparam logic [1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
	localparam logic [1:0] ST_STALE        = 2'd2;
	localparam logic [1:0] ST_FREE_RELEASE = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [8:0]  slot_index;
		logic [31:0] handle_id;
	} gsp_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  result_index;
		logic [31:0] result_handle;
	} gsp_rsp_t;

endpackage

// File: rtl/core/generational_slot_pool_core.sv
// ----------------------------------------------------------------------------
// generational_slot_pool_core
// Slot allocator handing out generation-tagged handles (gen << 16 | index):
// acquire, release and lookup commands against a slot table memory.
// ----------------------------------------------------------------------------
// Latency: an item accepted at edge N is processed in the cycle after N;
//   its result sits on the result ports, with done high, in the cycle after that.
// Flow: no new item is accepted while one is in stage 1. Each item reads its slot
//   entry from the table memory (registered read), then modifies and writes it back;
//   busy covers the read-to-write cycle. Results cannot be stalled.
// Reset: control registers clear at once. The table memories are not cleared:
//   entries at or above the fresh count were never handed out and read as free
//   with generation zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module generational_slot_pool_core #(
	parameter int BLOCK_SLOTS = gsp_pkg::BLOCK_SLOTS_DEF,
	parameter int MAX_BLOCKS  = gsp_pkg::MAX_BLOCKS_DEF,
	parameter int GEN_BITS    = gsp_pkg::GEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gsp_pkg::gsp_req_t request,
	output logic              done,
	output gsp_pkg::gsp_rsp_t result
);
	import gsp_pkg::*;

	localparam int TOTAL  = BLOCK_SLOTS * MAX_BLOCKS;
	localparam int SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CNT_W  = $clog2(TOTAL + 1);
	localparam int BLK_W  = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
	localparam int ENT_W  = GEN_BITS + 1;     // {in_use, generation}
	localparam int LINK_W = SLOT_W + 1;       // {end mark, next slot}
	localparam logic [31:0] TOTAL32 = 32'(TOTAL);

	// slot table and free-stack links
	logic [ENT_W-1:0]  entry_mem [TOTAL];
	logic [LINK_W-1:0] link_mem  [TOTAL];

	// control state
	logic              valid_s1;
	logic [SLOT_W-1:0] free_top_q;
	logic              free_empty_q;
	logic [CNT_W-1:0]  fresh_q;       // fresh slots handed out
	logic [CNT_W-1:0]  opened_q;      // slots in opened blocks
	logic [BLK_W-1:0]  blk_pos_q;     // position of fresh_q inside its block

	// stage 1: item and read data
	gsp_req_t          req_s1;
	logic [SLOT_W-1:0] addr_s1;
	logic [ENT_W-1:0]  entry_s1;
	logic [LINK_W-1:0] link_s1;

	// result register
	logic              done_q;
	gsp_rsp_t          result_q;

	logic              accept;
	logic [SLOT_W-1:0] rd_addr;

	// stage 1 decode
	logic              known;
	logic              use_rd;
	logic [GEN_BITS-1:0] gen_rd;
	logic [GEN_BITS-1:0] gen_inc;
	logic [15:0]       idx16;
	logic [31:0]       slot_ext;
	logic [31:0]       lkp_ext;
	logic [31:0]       fresh_ext;

	logic              ent_we;
	logic              link_we;
	logic [SLOT_W-1:0] wr_addr;
	logic [ENT_W-1:0]  ent_wdata;
	logic [LINK_W-1:0] link_wdata;
	logic [SLOT_W-1:0] free_top_nxt;
	logic              free_empty_nxt;
	logic              fresh_take;
	gsp_rsp_t          rsp_nxt;

	assign accept = start && !busy;
	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;

	// read address chosen from the incoming command
	always_comb begin
		case (request.cmd)
			CMD_ACQUIRE: rd_addr = free_top_q;
			CMD_RELEASE: rd_addr = SLOT_W'(request.slot_index);
			CMD_LOOKUP:  rd_addr = SLOT_W'(request.handle_id[15:0]);
			default:     rd_addr = '0;
		endcase
	end

	// table memories: registered read, at most one write to each memory per item
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_mem[rd_addr];
			link_s1  <= link_mem[rd_addr];
		end
		if (ent_we)
			entry_mem[wr_addr] <= ent_wdata;
		if (link_we)
			link_mem[wr_addr] <= link_wdata;
	end

	// entries at or above the fresh count were never written: free, gen zero
	assign fresh_ext = 32'(fresh_q);
	assign known     = 32'(addr_s1) < fresh_ext;
	assign use_rd    = known && entry_s1[GEN_BITS];
	assign gen_rd    = known ? entry_s1[GEN_BITS-1:0] : '0;
	assign gen_inc   = gen_rd + 1'b1;
	assign slot_ext  = 32'(req_s1.slot_index);
	assign idx16     = req_s1.handle_id[15:0];
	assign lkp_ext   = 32'(idx16);

	always_comb begin
		logic [31:0] top_ext;
		logic [31:0] fr_slot_ext;
		top_ext        = 32'(free_top_q);
		fr_slot_ext    = 32'(fresh_q);
		ent_we         = 1'b0;
		link_we        = 1'b0;
		wr_addr        = addr_s1;
		ent_wdata      = '0;
		link_wdata     = '0;
		free_top_nxt   = free_top_q;
		free_empty_nxt = free_empty_q;
		fresh_take     = 1'b0;
		rsp_nxt.status        = ST_STALE;
		rsp_nxt.result_index  = '0;
		rsp_nxt.result_handle = '0;

		case (req_s1.cmd)
			CMD_ACQUIRE: begin
				if (!free_empty_q) begin
					// pop the free stack
					ent_we    = valid_s1;
					ent_wdata = {1'b1, gen_rd};
					if (link_s1[SLOT_W]) begin
						free_empty_nxt = 1'b1;
						free_top_nxt   = '0;
					end else begin
						free_top_nxt = link_s1[SLOT_W-1:0];
					end
					rsp_nxt.status        = ST_OK;
					rsp_nxt.result_index  = top_ext[8:0];
					rsp_nxt.result_handle = {16'(gen_rd), top_ext[15:0]};
				end else if (fresh_ext < TOTAL32) begin
					// next fresh slot, generation zero
					fresh_take = valid_s1;
					ent_we     = valid_s1;
					wr_addr    = fresh_q[SLOT_W-1:0];
					ent_wdata  = {1'b1, {GEN_BITS{1'b0}}};
					rsp_nxt.status        = ST_OK;
					rsp_nxt.result_index  = fr_slot_ext[8:0];
					rsp_nxt.result_handle = {16'h0, fr_slot_ext[15:0]};
				end else begin
					rsp_nxt.status = ST_EXHAUSTED;
				end
			end
			CMD_RELEASE: begin
				rsp_nxt.result_index = req_s1.slot_index;
				if (slot_ext >= TOTAL32) begin
					rsp_nxt.status        = ST_FREE_RELEASE;
					rsp_nxt.result_handle = {16'h0, slot_ext[15:0]};
				end else if (!use_rd) begin
					rsp_nxt.status        = ST_FREE_RELEASE;
					rsp_nxt.result_handle = {16'(gen_rd), slot_ext[15:0]};
				end else begin
					// retire the slot and push it
					ent_we         = valid_s1;
					ent_wdata      = {1'b0, gen_inc};
					link_we        = valid_s1;
					link_wdata     = free_empty_q ? {1'b1, {SLOT_W{1'b0}}}
					                              : {1'b0, free_top_q};
					free_top_nxt   = addr_s1;
					free_empty_nxt = 1'b0;
					rsp_nxt.status        = ST_OK;
					rsp_nxt.result_handle = {16'(gen_inc), slot_ext[15:0]};
				end
			end
			CMD_LOOKUP: begin
				if (lkp_ext < 32'(opened_q) && lkp_ext < TOTAL32 && use_rd &&
				    16'(gen_rd) == req_s1.handle_id[31:16]) begin
					rsp_nxt.status        = ST_OK;
					rsp_nxt.result_index  = lkp_ext[8:0];
					rsp_nxt.result_handle = {16'(gen_rd), idx16};
				end
			end
			default: begin
				rsp_nxt.status = ST_STALE;
			end
		endcase
	end

	// stage 1 capture of the item
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= request;
			addr_s1 <= rd_addr;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s1)
			result_q <= rsp_nxt;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
			free_top_q   <= '0;
			free_empty_q <= 1'b1;
			fresh_q      <= '0;
			opened_q     <= '0;
			blk_pos_q    <= '0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (valid_s1) begin
				free_top_q   <= free_top_nxt;
				free_empty_q <= free_empty_nxt;
			end
			if (fresh_take) begin
				fresh_q <= fresh_q + 1'b1;
				// first slot of a block opens the whole block
				if (blk_pos_q == '0)
					opened_q <= opened_q + CNT_W'(BLOCK_SLOTS);
				if (blk_pos_q == BLK_W'(BLOCK_SLOTS - 1))
					blk_pos_q <= '0;
				else
					blk_pos_q <= blk_pos_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("item in flight did not finish in one cycle");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		free_empty_q |-> free_top_q == '0)
		else $error("empty free stack with nonzero top");

	a_opened: assert property (@(posedge clk) disable iff (!arst_n)
		32'(opened_q) >= 32'(fresh_q) && 32'(fresh_q) <= TOTAL32)
		else $error("opened range behind fresh count");

endmodule
